/* sv/bitmap_page_allocator_rotor_assert.svh */
// assertion macros used by the allocator controller
`ifndef BITMAP_PAGE_ALLOCATOR_ROTOR_ASSERT_SVH
`define BITMAP_PAGE_ALLOCATOR_ROTOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define BPAR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// next-cycle implication
`define BPAR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`else

`define BPAR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BPAR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* sv/bpar_pkg.sv */
package bpar_pkg;

    localparam int MAP_DEPTH_BYTES = 512;
    localparam int MAP_AW          = $clog2(MAP_DEPTH_BYTES);
    localparam int USED_W          = $clog2(MAP_DEPTH_BYTES + 1);
    localparam int MAX_SHIFT       = 8;
    localparam int OFFSET_W        = 20;
    localparam int CFG_W           = 10;
    localparam int SHIFT_W         = 4;

    // configuration register indexes
    localparam logic REG_MAP_BYTES = 1'b0;
    localparam logic REG_SHIFT     = 1'b1;

    // request kinds
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_DOUBLE = 2'd2,
        ST_RANGE  = 2'd3
    } st_t;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic start_rd;
        logic scan_step;
        logic alloc_commit;
        logic free_commit;
        logic clr_step;
        logic st_set;
        st_t  st_val;
        logic out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_free;
        logic map_empty;
        logic pg_range;
        logic byte_nz;
        logic scan_last;
        logic bit_set;
        logic clr_last;
    } dp_sts_t;

endpackage

/* sv/bpar_ram.sv */
module bpar_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/bpar_ctrl.sv */
`include "bitmap_page_allocator_rotor_assert.svh"

module bpar_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  bpar_pkg::dp_sts_t sts,
    output bpar_pkg::dp_cmd_t cmd
);

    import bpar_pkg::*;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_START,
        S_SCAN,
        S_FCHK,
        S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd            = '0;
        cmd.st_val     = ST_OK;
        state_next     = state_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        case (state_reg)
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_START;
                end
            end
            S_START:
            begin
                if (sts.is_free)
                begin
                    if (sts.pg_range)
                    begin
                        cmd.st_set = 1'b1;
                        cmd.st_val = ST_RANGE;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        cmd.start_rd = 1'b1;
                        state_next   = S_FCHK;
                    end
                end
                else if (sts.map_empty)
                begin
                    cmd.st_set = 1'b1;
                    cmd.st_val = ST_FULL;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.start_rd = 1'b1;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.byte_nz)
                begin
                    cmd.alloc_commit = 1'b1;
                    state_next       = S_FIN;
                end
                else if (sts.scan_last)
                begin
                    cmd.st_set = 1'b1;
                    cmd.st_val = ST_FULL;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_FCHK:
            begin
                if (sts.bit_set)
                begin
                    cmd.st_set = 1'b1;
                    cmd.st_val = ST_DOUBLE;
                end
                else
                begin
                    cmd.free_commit = 1'b1;
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // never overwrite a result that has not been taken
    `BPAR_ASSERT_IMPL(a_load_free, clk, rst_n, cmd.out_load, !out_valid_reg || out_ready)
    `BPAR_ASSERT_NEXT(a_load_shows, clk, rst_n, cmd.out_load, out_valid_reg)
    // at most one map write per cycle
    `BPAR_ASSERT_IMPL(a_one_write, clk, rst_n, 1'b1,
        $onehot0({cmd.clr_step, cmd.alloc_commit, cmd.free_commit}))
    // scan only moves past an empty byte that is not the last
    `BPAR_ASSERT_IMPL(a_scan_step, clk, rst_n, cmd.scan_step, !sts.byte_nz && !sts.scan_last)

endmodule

/* sv/bpar_dp.sv */
module bpar_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bpar_pkg::dp_cmd_t             cmd,
    output bpar_pkg::dp_sts_t             sts,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [bpar_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          in_op,
    input  logic [bpar_pkg::OFFSET_W-1:0] in_offset,
    input  logic                          in_last,
    output logic [bpar_pkg::OFFSET_W-1:0] out_offset,
    output logic [1:0]                    out_status,
    output logic                          out_last
);

    import bpar_pkg::*;

    localparam int PAGE_W = MAP_AW + 3;
    localparam int WIDE_W = OFFSET_W + MAX_SHIFT;

    function automatic logic [2:0] low_bit(input logic [7:0] v);
        logic [2:0] b;
        b = 3'd7;
        for (int i = 7; i >= 0; i--)
        begin
            if (v[i])
            begin
                b = 3'(i);
            end
        end
        return b;
    endfunction

    logic [CFG_W-1:0]    map_bytes_reg;
    logic [SHIFT_W-1:0]  shift_cfg_reg;
    logic [MAP_AW-1:0]   rotor_reg;
    logic [MAP_AW-1:0]   pos_reg;
    logic [MAP_AW-1:0]   count_reg;
    logic [MAP_AW-1:0]   clr_cnt_reg;
    logic                op_reg;
    logic [OFFSET_W-1:0] off_reg;
    logic                bend_reg;
    logic [OFFSET_W-1:0] res_off_reg;
    st_t                 res_st_reg;
    logic [OFFSET_W-1:0] out_off_reg;
    logic [1:0]          out_st_reg;
    logic                out_last_reg;

    logic [USED_W-1:0]   used;
    logic [SHIFT_W-1:0]  shift;
    logic [OFFSET_W-1:0] page;
    logic [USED_W+2:0]   used_pages;
    logic [MAP_AW-1:0]   start_pos;
    logic [MAP_AW-1:0]   pos_inc;
    logic [USED_W-1:0]   pos_plus;
    logic [MAP_AW-1:0]   free_byte;
    logic [2:0]          free_bit;
    logic [2:0]          alloc_bit;
    logic [PAGE_W-1:0]   alloc_page;
    logic [WIDE_W-1:0]   alloc_wide;

    logic                mem_we;
    logic [MAP_AW-1:0]   mem_waddr;
    logic [7:0]          mem_wdata;
    logic                mem_re;
    logic [MAP_AW-1:0]   mem_raddr;
    logic [7:0]          mem_rdata;

    // saturate the configuration
    assign used  = (32'(map_bytes_reg) > MAP_DEPTH_BYTES) ? USED_W'(MAP_DEPTH_BYTES)
                                                          : USED_W'(map_bytes_reg);
    assign shift = (32'(shift_cfg_reg) > MAX_SHIFT) ? SHIFT_W'(MAX_SHIFT) : shift_cfg_reg;

    // return path: block offset to page, byte and bit
    assign page       = off_reg >> shift;
    assign used_pages = {used, 3'b000};
    assign free_byte  = page[PAGE_W-1:3];
    assign free_bit   = page[2:0];

    // scan path
    assign start_pos  = (USED_W'(rotor_reg) < used) ? rotor_reg : '0;
    assign pos_plus   = USED_W'(pos_reg) + USED_W'(1);
    assign pos_inc    = (pos_plus >= used) ? '0 : pos_plus[MAP_AW-1:0];
    assign alloc_bit  = low_bit(mem_rdata);
    assign alloc_page = {pos_reg, alloc_bit};
    assign alloc_wide = WIDE_W'(alloc_page) << shift;

    assign sts.is_free   = (op_reg == OP_FREE);
    assign sts.map_empty = (used == '0);
    assign sts.pg_range  = ({{(OFFSET_W-USED_W-3){1'b0}}, used_pages} <= page);
    assign sts.byte_nz   = (mem_rdata != 8'h00);
    assign sts.scan_last = ((USED_W'(count_reg) + USED_W'(1)) == used);
    assign sts.bit_set   = mem_rdata[free_bit];
    assign sts.clr_last  = (clr_cnt_reg == MAP_AW'(MAP_DEPTH_BYTES - 1));

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = pos_reg;
        mem_wdata = mem_rdata;
        if (cmd.clr_step)
        begin
            // page zero stays reserved
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = (clr_cnt_reg == '0) ? 8'hfe : 8'hff;
        end
        else if (cmd.alloc_commit)
        begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata & ~(8'h01 << alloc_bit);
        end
        else if (cmd.free_commit)
        begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata | (8'h01 << free_bit);
        end
    end

    assign mem_re    = cmd.start_rd | cmd.scan_step;
    assign mem_raddr = cmd.start_rd ? (sts.is_free ? free_byte : start_pos) : pos_inc;

    bpar_ram #(
        .WIDTH (8),
        .DEPTH (MAP_DEPTH_BYTES)
    ) u_map (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_bytes_reg <= CFG_W'(MAP_DEPTH_BYTES);
            shift_cfg_reg <= SHIFT_W'(3);
            rotor_reg     <= '0;
            pos_reg       <= '0;
            count_reg     <= '0;
            clr_cnt_reg   <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_MAP_BYTES)
            begin
                map_bytes_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == REG_SHIFT)
            begin
                shift_cfg_reg <= cfg_data[SHIFT_W-1:0];
            end
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + MAP_AW'(1);
            end
            if (cmd.start_rd)
            begin
                pos_reg   <= mem_raddr;
                count_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                pos_reg   <= pos_inc;
                count_reg <= count_reg + MAP_AW'(1);
            end
            if (cmd.alloc_commit)
            begin
                rotor_reg <= pos_reg;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg      <= in_op;
            off_reg     <= in_offset;
            bend_reg    <= in_last;
            res_off_reg <= '0;
            res_st_reg  <= ST_OK;
        end
        if (cmd.st_set)
        begin
            res_st_reg <= cmd.st_val;
        end
        if (cmd.alloc_commit)
        begin
            res_off_reg <= alloc_wide[OFFSET_W-1:0];
        end
        if (cmd.out_load)
        begin
            out_off_reg  <= res_off_reg;
            out_st_reg   <= res_st_reg;
            out_last_reg <= (op_reg == OP_FREE) ? bend_reg : 1'b0;
        end
    end

    assign out_offset = out_off_reg;
    assign out_status = out_st_reg;
    assign out_last   = out_last_reg;

endmodule

/* sv/bitmap_page_allocator_rotor.sv */
// next-fit page allocator over a free-page bitmap (bit set = page free). after reset the
// block sweeps the 512-byte map once, one byte a cycle, so it takes no request until the
// sweep is done (configuration writes are taken at any time). an allocate (s_tuser 0)
// scans bitmap bytes from the rotor, wrapping once over the bytes in use, takes the lowest
// free page of the first nonzero byte and returns its block offset; it looks at up to
// map_bytes_used bytes, one byte a cycle as set by the single read port of the bitmap ram.
// a return (s_tuser 1) reads its byte and, unless the page is already free, writes it back
// with the page's bit set (no map access when the page is out of range). one request is
// in work at a time; a finished result sits in the output register while the next request
// is accepted
module bitmap_page_allocator_rotor (
    input  logic                       clk,
    input  logic                       rst_n,
    // request stream
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [23:0]                s_tdata,   // [19:0] block_offset, [23:20] zero
    input  logic [0:0]                 s_tuser,   // [0] op
    input  logic                       s_tlast,   // batch_end
    // result stream
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [23:0]                m_tdata,   // [19:0] alloc_offset, [23:20] zero
    output logic [1:0]                 m_tuser,   // [1:0] status
    output logic                       m_tlast,   // batch_done
    // configuration writes
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       cfg_index, // 0 map_bytes_used, 1 blocks_per_page_log2
    input  logic [bpar_pkg::CFG_W-1:0] cfg_data
);

    import bpar_pkg::*;

    dp_cmd_t             cmd;
    dp_sts_t             sts;
    logic [OFFSET_W-1:0] out_offset;

    // registers are always writable; user must keep block idle when they change (unchecked)
    assign cfg_ready = 1'b1;

    bpar_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    bpar_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .cfg_we     (cfg_valid & cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_op      (s_tuser[0]),
        .in_offset  (s_tdata[OFFSET_W-1:0]),
        .in_last    (s_tlast),
        .out_offset (out_offset),
        .out_status (m_tuser),
        .out_last   (m_tlast)
    );

    // pad the offset to whole bytes
    assign m_tdata = {{(24-OFFSET_W){1'b0}}, out_offset};

endmodule
